// ===== src/windowed_average_tracker_top_defines.svh =====
// Assertion macros shared by the windowed average tracker RTL.
// Included by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef WINDOWED_AVERAGE_TRACKER_TOP_DEFINES_SVH
`define WINDOWED_AVERAGE_TRACKER_TOP_DEFINES_SVH

// check sampled on clk, masked while in reset
`define WAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that also holds while reset is asserted
`define WAT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/wat_pkg.sv =====
// Package for the windowed average tracker: widths, op codes, states, divider structs.
// No dependencies.
package wat_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SLOPE_W  = 17;
  localparam int SUM_W    = 24;
  localparam int ADDR_W   = 8;
  localparam int DEPTH    = 256;
  localparam int CNT_W    = 9;
  localparam int LOG_W    = 4;
  localparam int MAX_LOG  = 8;
  localparam int DIVC_W   = 5;
  localparam int OUT_W    = 56;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_TRIM  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [LOG_W-1:0] WINDOW_RST = 4'd3;
  localparam logic signed [SAMPLE_W-1:0] MIN_RST = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] MAX_RST = 16'sh8000;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_ADD_RD = 11'b000_0000_0010,
    S_ADD_DA = 11'b000_0000_0100,
    S_ADD_DS = 11'b000_0000_1000,
    S_T1A    = 11'b000_0001_0000,
    S_T1B    = 11'b000_0010_0000,
    S_T2A    = 11'b000_0100_0000,
    S_T2B    = 11'b000_1000_0000,
    S_T3     = 11'b001_0000_0000,
    S_T4     = 11'b010_0000_0000,
    S_FIN    = 11'b100_0000_0000
  } state_t;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic [CNT_W-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic signed [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== src/wat_div.sv =====
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on wat_pkg.
module wat_div import wat_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r, done_r, neg_r;
  logic [DIVC_W-1:0] cnt_r;
  logic [SUM_W-1:0]  mag_r;
  logic [CNT_W:0]    rem_r;
  logic [CNT_W-1:0]  d_r;
  logic [CNT_W:0]    trial;
  logic              qbit;

  // restoring step
  always_comb begin
    trial = {rem_r[CNT_W-1:0], mag_r[SUM_W-1]};
    qbit  = (trial >= {1'b0, d_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        neg_r  <= req.dividend[SUM_W-1];
        mag_r  <= req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : SUM_W'(req.dividend);
        rem_r  <= '0;
        d_r    <= req.divisor;
      end else if (busy_r) begin
        rem_r <= qbit ? trial - {1'b0, d_r} : trial;
        mag_r <= {mag_r[SUM_W-2:0], qbit};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIVC_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? -$signed(mag_r) : $signed(mag_r);

endmodule

// ===== src/windowed_average_tracker_top.sv =====
// Top level of the windowed average tracker: sample ring, sequencer, output register.
// Depends on wat_pkg, wat_div and windowed_average_tracker_top_defines.svh.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tuser op, tdata sample
//  out_    | out | out_tvalid/tready  | tdata average, slope, spread, at_peak, at_valley
//  cfg_    | in  | cfg_we             | cfg_wdata window_log2
//
// Add while the ring fills: two passes through the serial divider.
// Add once the ring is full: a shift instead of a divide.
// Trim request: two read passes over the n filled slots, then a divide of the kept sum.
// Clear and unused ops go straight to the output state. in_tready is high only in idle; a
// waiting result does not block the next request until that request finishes. Reset is
// synchronous active low; the ring needs no clearing pass, the fill count hides unwritten slots.
`include "windowed_average_tracker_top_defines.svh"
module windowed_average_tracker_top import wat_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [SAMPLE_W-1:0] in_tdata,   // [15:0] sample
  input  logic [1:0]          in_tuser,   // [1:0] op
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_W-1:0]    out_tdata,  // [15:0] average, [32:16] slope, [48:33] spread,
                                          // [49] at_peak, [50] at_valley
  input  logic                cfg_we,
  input  logic [LOG_W-1:0]    cfg_wdata
);

  state_t                     st_r;
  logic [LOG_W-1:0]           window_r;
  logic [ADDR_W-1:0]          write_pos_r;
  logic [CNT_W-1:0]           fill_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [SAMPLE_W-1:0] track_min_r, track_max_r;
  logic                       track_valid_r;
  logic signed [SLOPE_W-1:0]  prev_slope_r;
  logic [1:0]                 op_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [SAMPLE_W-1:0] avg_r;
  logic signed [SLOPE_W-1:0]  slope_r, diff_r;
  logic [CNT_W-1:0]           idx_r, k_r;
  logic signed [SAMPLE_W-1:0] hi_r, lo_r;
  logic [ADDR_W-1:0]          hi_i_r, lo_i_r;
  logic signed [SUM_W-1:0]    acc_r;
  logic                       out_valid_r;
  logic [OUT_W-1:0]           out_data_r;
  div_req_t                   div_req_r;
  div_rsp_t                   div_rsp;

  logic signed [SAMPLE_W-1:0] ring [DEPTH];
  logic signed [SAMPLE_W-1:0] rd_data_r;
  logic [ADDR_W-1:0]          rd_addr, pos, win_mask;
  logic [LOG_W-1:0]           p_eff;
  logic [CNT_W-1:0]           win_len, ncnt;
  logic                       full_before, ram_we, is_last;
  logic signed [SAMPLE_W-1:0] old_v;
  logic signed [SLOPE_W-1:0]  diff_v;
  logic signed [SUM_W-1:0]    diff_x, sum_new;
  logic signed [SLOPE_W-1:0]  fin_slope;
  logic [SAMPLE_W:0]          spread_w;
  logic [SAMPLE_W-1:0]        spread_v;
  logic                       peak_v, valley_v, out_free;

  // window geometry
  always_comb begin
    p_eff    = (window_r > LOG_W'(MAX_LOG)) ? LOG_W'(MAX_LOG) : window_r;
    win_len  = CNT_W'(1) << p_eff;
    win_mask = ADDR_W'(win_len - 1'b1);
    pos      = write_pos_r & win_mask;
    rd_addr  = (st_r == S_IDLE) ? pos : idx_r[ADDR_W-1:0];
    is_last  = (idx_r == fill_r - 1'b1);
  end

  // add datapath: slot is zero until the ring has wrapped
  always_comb begin
    full_before = (fill_r == win_len);
    old_v       = full_before ? rd_data_r : '0;
    diff_v      = SLOPE_W'(sample_r) - SLOPE_W'(old_v);
    diff_x      = SUM_W'(diff_v);
    sum_new     = sum_r + diff_x;
    ncnt        = full_before ? fill_r : fill_r + 1'b1;
    ram_we      = (st_r == S_ADD_RD);
  end

  // sample ring
  always_ff @(posedge clk) begin
    if (ram_we) begin
      ring[pos] <= sample_r;
    end
    rd_data_r <= ring[rd_addr];
  end

  // result assembly
  always_comb begin
    fin_slope = (op_r == OP_ADD) ? slope_r : '0;
    peak_v    = (op_r == OP_ADD) && (prev_slope_r > 0) && (slope_r < 0);
    valley_v  = (op_r == OP_ADD) && (prev_slope_r < 0) && (slope_r > 0);
    spread_w  = (SAMPLE_W+1)'(track_max_r) - (SAMPLE_W+1)'(track_min_r);
    spread_v  = ((op_r == OP_ADD || op_r == OP_TRIM) && track_valid_r) ?
                spread_w[SAMPLE_W-1:0] : '0;
    out_free  = !out_valid_r || out_tready;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= S_IDLE;
      window_r      <= WINDOW_RST;
      write_pos_r   <= '0;
      fill_r        <= '0;
      sum_r         <= '0;
      prev_slope_r  <= '0;
      track_min_r   <= MIN_RST;
      track_max_r   <= MAX_RST;
      track_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
      div_req_r     <= '0;
    end else begin
      div_req_r.start <= 1'b0;
      if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        window_r      <= cfg_wdata;
        write_pos_r   <= '0;
        fill_r        <= '0;
        sum_r         <= '0;
        prev_slope_r  <= '0;
        track_min_r   <= MIN_RST;
        track_max_r   <= MAX_RST;
        track_valid_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r     <= in_tuser;
            sample_r <= in_tdata;
            avg_r    <= '0;
            slope_r  <= '0;
            idx_r    <= '0;
            acc_r    <= '0;
            k_r      <= '0;
            case (in_tuser)
              OP_ADD: st_r <= S_ADD_RD;
              OP_TRIM: begin
                track_min_r   <= MIN_RST;
                track_max_r   <= MAX_RST;
                track_valid_r <= 1'b0;
                st_r <= (fill_r == '0) ? S_FIN : S_T1A;
              end
              OP_CLEAR: begin
                track_min_r   <= MIN_RST;
                track_max_r   <= MAX_RST;
                track_valid_r <= 1'b0;
                st_r <= S_FIN;
              end
              default: st_r <= S_FIN;
            endcase
          end
        end
        S_ADD_RD: begin
          sum_r       <= sum_new;
          diff_r      <= diff_v;
          write_pos_r <= (pos + 1'b1) & win_mask;
          fill_r      <= ncnt;
          if (sample_r > track_max_r) track_max_r <= sample_r;
          if (sample_r < track_min_r) track_min_r <= sample_r;
          track_valid_r <= 1'b1;
          if (ncnt < win_len) begin
            div_req_r <= '{start: 1'b1, dividend: sum_new, divisor: ncnt};
            st_r      <= S_ADD_DA;
          end else begin
            avg_r   <= SAMPLE_W'(sum_new >>> p_eff);
            slope_r <= SLOPE_W'(diff_x >>> p_eff);
            st_r    <= S_FIN;
          end
        end
        S_ADD_DA: begin
          if (div_rsp.done) begin
            avg_r     <= div_rsp.quotient[SAMPLE_W-1:0];
            div_req_r <= '{start: 1'b1, dividend: SUM_W'(diff_r), divisor: fill_r};
            st_r      <= S_ADD_DS;
          end
        end
        S_ADD_DS: begin
          if (div_rsp.done) begin
            slope_r <= div_rsp.quotient[SLOPE_W-1:0];
            st_r    <= S_FIN;
          end
        end
        S_T1A: st_r <= S_T1B;
        S_T1B: begin
          // first largest and first smallest slot
          if (idx_r == '0 || rd_data_r > hi_r) begin
            hi_r   <= rd_data_r;
            hi_i_r <= idx_r[ADDR_W-1:0];
          end
          if (idx_r == '0 || rd_data_r < lo_r) begin
            lo_r   <= rd_data_r;
            lo_i_r <= idx_r[ADDR_W-1:0];
          end
          if (is_last) begin
            idx_r <= '0;
            st_r  <= S_T2A;
          end else begin
            idx_r <= idx_r + 1'b1;
            st_r  <= S_T1A;
          end
        end
        S_T2A: st_r <= S_T2B;
        S_T2B: begin
          if (idx_r[ADDR_W-1:0] != hi_i_r && idx_r[ADDR_W-1:0] != lo_i_r) begin
            if (rd_data_r > track_max_r) track_max_r <= rd_data_r;
            if (rd_data_r < track_min_r) track_min_r <= rd_data_r;
            track_valid_r <= 1'b1;
            acc_r <= acc_r + SUM_W'(rd_data_r);
            k_r   <= k_r + 1'b1;
          end
          idx_r <= idx_r + 1'b1;
          st_r  <= is_last ? S_T3 : S_T2A;
        end
        S_T3: begin
          if (k_r == '0) begin
            st_r <= S_FIN;
          end else begin
            div_req_r <= '{start: 1'b1, dividend: acc_r, divisor: k_r};
            st_r      <= S_T4;
          end
        end
        S_T4: begin
          if (div_rsp.done) begin
            avg_r <= div_rsp.quotient[SAMPLE_W-1:0];
            st_r  <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {5'b0, valley_v, peak_v, spread_v, fin_slope, avg_r};
            if (op_r == OP_ADD) prev_slope_r <= slope_r;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  wat_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .rsp   (div_rsp)
  );

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `WAT_ASSERT(a_fill_le_len, fill_r <= win_len, "fill count beyond window length")
  `WAT_ASSERT(a_pos_in_win, (write_pos_r & win_mask) == write_pos_r, "position off window")
  `WAT_ASSERT(a_div_idle_start, div_req_r.start |-> !div_rsp.busy, "divider started while busy")
  `WAT_ASSERT(a_accept_leaves_idle, in_tvalid && in_tready |=> (st_r != S_IDLE), "stayed idle")

endmodule
